@@ rtl/vbv_mon_pkg.sv @@
package vbv_mon_pkg;

    localparam int QUEUE_DEPTH = 1024;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int BYTES_W = 24;
    localparam int OCC_W   = 25;
    localparam int STAMP_W = 33;
    localparam int LOW_W   = 34;
    localparam int CFG_W   = 33;

    localparam logic [OCC_W-1:0]   BUF_SIZE_RST    = OCC_W'(819200);
    localparam logic [STAMP_W-1:0] START_DELAY_RST = STAMP_W'(54000);
    localparam logic [LOW_W-1:0]   LOW_UNSET       = '1;

    typedef enum logic [0:0] {
        CFG_BUFFER_SIZE = 1'b0,
        CFG_START_DELAY = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        EV_NONE      = 2'd0,
        EV_OVERFLOW  = 2'd1,
        EV_UNDERFLOW = 2'd2,
        EV_ALARM     = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        FLAGS_PTS     = 2'd1,
        FLAGS_PTS_DTS = 2'd3
    } t_flags;

    typedef enum logic [0:0] {
        ACT_ARRIVE = 1'b0,
        ACT_TICK   = 1'b1
    } t_action;

endpackage

@@ rtl/vbv_mon_item_if.sv @@
interface vbv_mon_item_if
    import vbv_mon_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               action;
    logic [BYTES_W-1:0] packet_bytes;
    logic [1:0]         stamp_flags;
    logic [STAMP_W-1:0] presentation_stamp;
    logic [STAMP_W-1:0] decode_stamp;

    modport source (
        output valid, action, packet_bytes, stamp_flags, presentation_stamp, decode_stamp,
        input  ready
    );
    modport sink (
        input  valid, action, packet_bytes, stamp_flags, presentation_stamp, decode_stamp,
        output ready
    );
endinterface

@@ rtl/vbv_mon_result_if.sv @@
interface vbv_mon_result_if
    import vbv_mon_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             accepted;
    logic [1:0]       event_res;
    logic [OCC_W-1:0] occupancy;
    logic             drain_active;

    modport source (
        output valid, accepted, event_res, occupancy, drain_active,
        input  ready
    );
    modport sink (
        input  valid, accepted, event_res, occupancy, drain_active,
        output ready
    );
endinterface

@@ rtl/vbv_buffer_occupancy_monitor_core.sv @@
// Decoder buffer occupancy monitor: one result beat per input beat.
// A packet arrival goes straight to the result register; so does a frame tick
// when not draining or on underflow, else the tick first passes through the queue
// memory read, occupancy subtract and fullness compare. One item in flight.
// Reset (i_rst_n low, synchronous): queue empty, marks unset, draining off, result
// valid clear, config registers back to defaults. Queue memory contents are not cleared.
module vbv_buffer_occupancy_monitor_core
    import vbv_mon_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [0:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    vbv_mon_item_if.sink     i_item,
    vbv_mon_result_if.source o_result
);

    // one-hot sequencer: idle, queue read in flight, fullness check
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_READ  = 3'b010,
        S_CHECK = 3'b100
    } t_state;

    // configuration
    logic [OCC_W-1:0]   r_buf_size;
    logic [STAMP_W-1:0] r_start_delay;

    // buffer state; the size queue lives in a memory with one write port and one registered read port
    logic [BYTES_W-1:0] r_mem [QUEUE_DEPTH];
    logic [BYTES_W-1:0] r_rd_data;
    logic [QIDX_W-1:0]  r_head, n_head;
    logic [QIDX_W-1:0]  r_tail, n_tail;
    logic [QCNT_W-1:0]  r_count, n_count;
    logic [OCC_W-1:0]   r_used, n_used;
    logic [LOW_W-1:0]   r_low, n_low;
    logic [STAMP_W-1:0] r_high, n_high;
    logic               r_draining, n_draining;
    t_state             r_state, n_state;

    // result register
    logic               r_out_valid, n_out_valid;
    logic               r_out_acc, n_out_acc;
    t_event             r_out_ev, n_out_ev;

    logic               in_fire;
    logic               out_free;
    logic               wr_en;
    logic [OCC_W:0]     sum_used;
    logic               fits;
    logic [STAMP_W-1:0] stamp;
    logic [LOW_W-1:0]   spread;
    logic               start_ok;
    logic [OCC_W+5:0]   used_x40;
    logic [OCC_W+4:0]   used_x25;
    logic [OCC_W+4:0]   size_x24;
    logic               alarm;

    // result register drains whenever the sink takes it; a new item may
    // enter in the same cycle the old result leaves
    assign out_free     = !r_out_valid || o_result.ready;
    assign i_item.ready = (r_state == S_IDLE) && out_free;
    assign in_fire      = i_item.valid && i_item.ready;

    assign o_result.valid        = r_out_valid;
    assign o_result.accepted     = r_out_acc;
    assign o_result.event_res    = r_out_ev;
    assign o_result.occupancy    = r_used;
    assign o_result.drain_active = r_draining;

    // admission: strictly below capacity and a free queue slot
    assign sum_used = {1'b0, r_used} + {2'b0, i_item.packet_bytes};
    assign fits     = (sum_used < {1'b0, r_buf_size}) && (r_count != QCNT_W'(QUEUE_DEPTH));

    always_comb begin
        case (i_item.stamp_flags)
            FLAGS_PTS:     stamp = i_item.presentation_stamp;
            FLAGS_PTS_DTS: stamp = i_item.decode_stamp;
            default:       stamp = '0;
        endcase
    end

    // draining starts once the mark spread exceeds the start delay
    assign spread   = {1'b0, r_high} - r_low;
    assign start_ok = (r_low != LOW_UNSET) && (r_high != '0)
                   && ({1'b0, r_high} > r_low)
                   && (spread > {1'b0, r_start_delay});

    // fullness alarm at or below 1/40 or at or above 24/25 of capacity
    assign used_x40 = {1'b0, r_used, 5'b0} + {3'b0, r_used, 3'b0};
    assign used_x25 = {1'b0, r_used, 4'b0} + {2'b0, r_used, 3'b0} + {5'b0, r_used};
    assign size_x24 = {1'b0, r_buf_size, 4'b0} + {2'b0, r_buf_size, 3'b0};
    assign alarm    = (used_x40 <= {6'b0, r_buf_size}) || (used_x25 >= size_x24);

    assign wr_en = in_fire && (i_item.action == ACT_ARRIVE) && fits;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_used      = r_used;
        n_low       = r_low;
        n_high      = r_high;
        n_draining  = r_draining;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out_acc   = r_out_acc;
        n_out_ev    = r_out_ev;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_item.action == ACT_ARRIVE) begin
                        n_out_valid = 1'b1;
                        if (fits) begin
                            n_tail    = (r_tail == QIDX_W'(QUEUE_DEPTH - 1)) ?
                                        '0 : r_tail + QIDX_W'(1);
                            n_count   = r_count + QCNT_W'(1);
                            n_used    = sum_used[OCC_W-1:0];
                            if (stamp > r_high) begin
                                n_high = stamp;
                            end
                            if ((stamp != '0) && ({1'b0, stamp} <= r_low)) begin
                                n_low = {1'b0, stamp};
                            end
                            n_out_acc = 1'b1;
                            n_out_ev  = EV_NONE;
                        end else begin
                            n_out_acc = 1'b0;
                            n_out_ev  = EV_OVERFLOW;
                        end
                    end else begin
                        n_out_acc = 1'b0;
                        if (r_draining || start_ok) begin
                            n_draining = 1'b1;
                            if (r_count == '0) begin
                                n_out_valid = 1'b1;
                                n_out_ev    = EV_UNDERFLOW;
                            end else begin
                                // head entry is read this cycle
                                n_state = S_READ;
                            end
                        end else begin
                            n_out_valid = 1'b1;
                            n_out_ev    = EV_NONE;
                        end
                    end
                end
            end
            S_READ: begin
                n_used  = (r_used >= {1'b0, r_rd_data}) ? r_used - {1'b0, r_rd_data} : '0;
                n_head  = (r_head == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + QIDX_W'(1);
                n_count = r_count - QCNT_W'(1);
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_out_valid = 1'b1;
                n_out_ev    = alarm ? EV_ALARM : EV_NONE;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_head        <= '0;
            r_tail        <= '0;
            r_count       <= '0;
            r_used        <= '0;
            r_low         <= LOW_UNSET;
            r_high        <= '0;
            r_draining    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_buf_size    <= BUF_SIZE_RST;
            r_start_delay <= START_DELAY_RST;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_used      <= n_used;
            r_low       <= n_low;
            r_high      <= n_high;
            r_draining  <= n_draining;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BUFFER_SIZE: r_buf_size    <= i_cfg_data[OCC_W-1:0];
                    CFG_START_DELAY: r_start_delay <= i_cfg_data[STAMP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_acc <= n_out_acc;
        r_out_ev  <= n_out_ev;
    end

    // size queue: write at tail on admission, registered read at head
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_tail] <= i_item.packet_bytes;
        end
        r_rd_data <= r_mem[r_head];
    end

endmodule
